// ===== rtl/mm4_pkg.sv =====
package mm4_pkg;

  localparam int DIM    = 4;
  localparam int NELEM  = DIM * DIM;
  localparam int IDX_W  = $clog2(NELEM);
  localparam int Z_W    = $clog2(DIM);
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + Z_W;

  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [3:0]               element_index;
    logic signed [DATA_W-1:0] element_value;
  } mm4_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] product_value;
    logic [3:0]               result_index;
    logic                     last_result;
  } mm4_out_t;

  // control that travels alongside one multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             first;   // z == 0, restart the sum
    logic             last_z;  // z == DIM-1, sum complete
    logic             last;    // final element of the run
    logic [IDX_W-1:0] idx;
  } mm4_ctl_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_DRAIN
  } mm4_seq_state_t;

endpackage

// ===== rtl/mm4_ram.sv =====
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mm4_seq.sv =====
module mm4_seq import mm4_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             adv,
  input  logic             done,
  output logic             idle,
  output mm4_ctl_t         issue,
  output logic [IDX_W-1:0] a_addr,
  output logic [IDX_W-1:0] b_addr
);

  mm4_seq_state_t state_r, state_nxt;
  logic [Z_W-1:0] x_r, x_nxt;
  logic [Z_W-1:0] y_r, y_nxt;
  logic [Z_W-1:0] z_r, z_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic last_issue;

  localparam logic [Z_W-1:0] ZMAX = Z_W'(DIM - 1);

  assign last_issue = (z_r == ZMAX) && (idx_r == IDX_W'(NELEM - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE:  if (start) state_nxt = SEQ_RUN;
      SEQ_RUN:   if (adv && last_issue) state_nxt = SEQ_DRAIN;
      SEQ_DRAIN: if (done) state_nxt = SEQ_IDLE;
      default:   state_nxt = SEQ_IDLE;
    endcase
  end

  // loop counters: z innermost, then x, then y
  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    z_nxt   = z_r;
    idx_nxt = idx_r;
    if (state_r == SEQ_IDLE) begin
      x_nxt   = '0;
      y_nxt   = '0;
      z_nxt   = '0;
      idx_nxt = '0;
    end else if (state_r == SEQ_RUN && adv) begin
      if (z_r == ZMAX) begin
        z_nxt   = '0;
        idx_nxt = idx_r + IDX_W'(1);
        if (x_r == ZMAX) begin
          x_nxt = '0;
          y_nxt = y_r + Z_W'(1);
        end else begin
          x_nxt = x_r + Z_W'(1);
        end
      end else begin
        z_nxt = z_r + Z_W'(1);
      end
    end
  end

  // outputs
  always_comb begin
    idle         = (state_r == SEQ_IDLE);
    issue.valid  = (state_r == SEQ_RUN);
    issue.first  = (z_r == '0);
    issue.last_z = (z_r == ZMAX);
    issue.last   = last_issue;
    issue.idx    = idx_r;
    a_addr       = IDX_W'(x_r) + IDX_W'(z_r) * IDX_W'(DIM);
    b_addr       = IDX_W'(z_r) + IDX_W'(y_r) * IDX_W'(DIM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      x_r     <= '0;
      y_r     <= '0;
      z_r     <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== rtl/mm4_mac.sv =====
module mm4_mac import mm4_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mm4_ctl_t          issue,
  input  logic [DATA_W-1:0] a_data,
  input  logic [DATA_W-1:0] b_data,
  input  logic              out_ready,
  output logic              adv,
  output logic              done,
  output logic              out_valid,
  output mm4_out_t          out_data
);

  mm4_ctl_t ctl1_r, ctl2_r, ctl3_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_base, acc_nxt, shifted;
  logic [ACC_W-DATA_W:0]    upper;
  logic signed [DATA_W-1:0] sat;
  logic fin;
  logic out_valid_r;
  mm4_out_t out_data_r;

  // whole pipeline holds while a result waits in the output register
  assign adv = !out_valid_r || out_ready;
  assign fin = ctl3_r.valid && ctl3_r.last_z;
  assign done = adv && fin && ctl3_r.last;

  always_comb begin
    acc_base = ctl2_r.first ? '0 : acc_r;
    acc_nxt  = acc_base + ACC_W'(prod_r);
  end

  // arithmetic shift floors; saturate if the upper bits are not a pure sign run
  always_comb begin
    shifted = acc_r >>> FRAC_BITS;
    upper   = shifted[ACC_W-1:DATA_W-1];
    if (&upper || ~|upper) begin
      sat = shifted[DATA_W-1:0];
    end else if (upper[ACC_W-DATA_W]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r      <= '0;
      ctl2_r      <= '0;
      ctl3_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      ctl1_r      <= issue;
      ctl2_r      <= ctl1_r;
      ctl3_r      <= ctl2_r;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= signed'(a_data) * signed'(b_data);
      if (ctl2_r.valid) begin
        acc_r <= acc_nxt;
      end
      if (fin) begin
        out_data_r.product_value <= sat;
        out_data_r.result_index  <= 4'(ctl3_r.idx);
        out_data_r.last_result   <= ctl3_r.last;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/matrix4x4_multiply.sv =====
// Loads: one transaction per cycle while idle, written to the A or B memory at
// acceptance. Compute: each result sums four terms, with one memory read pair and
// one 32x32 multiply per term, for a run of 16 results; in_ready returns when the
// last result is registered. Output stalls hold the whole pipeline.
// Reset (rst_n low, synchronous) clears control only; matrix contents are undefined.
module matrix4x4_multiply import mm4_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mm4_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mm4_out_t out_data
);

  logic in_fire, start, we_a, we_b;
  logic adv, done, idle;
  mm4_ctl_t issue;
  logic [IDX_W-1:0] a_addr, b_addr, waddr;
  logic [DATA_W-1:0] a_data, b_data;

  // no loads are taken during a run, so reads and writes never overlap
  assign in_ready = idle;
  assign in_fire  = in_valid && in_ready;
  assign start    = in_fire && (in_data.req_type == REQ_COMPUTE);
  assign we_a     = in_fire && (in_data.req_type == REQ_LOAD_A);
  assign we_b     = in_fire && (in_data.req_type == REQ_LOAD_B);
  assign waddr    = IDX_W'(in_data.element_index);

  mm4_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .adv    (adv),
    .done   (done),
    .idle   (idle),
    .issue  (issue),
    .a_addr (a_addr),
    .b_addr (b_addr)
  );

  mm4_ram #(.WIDTH(DATA_W), .DEPTH(NELEM)) u_mem_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_data.element_value),
    .re    (adv && issue.valid),
    .raddr (a_addr),
    .rdata (a_data)
  );

  mm4_ram #(.WIDTH(DATA_W), .DEPTH(NELEM)) u_mem_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_data.element_value),
    .re    (adv && issue.valid),
    .raddr (b_addr),
    .rdata (b_data)
  );

  mm4_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .a_data    (a_data),
    .b_data    (b_data),
    .out_ready (out_ready),
    .adv       (adv),
    .done      (done),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/mm4_checker.sv =====
module mm4_checker import mm4_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input mm4_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input mm4_out_t out_data
);

  // a compute transaction locks out further input
  a_compute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.req_type == REQ_COMPUTE |=> !in_ready)
    else $error("input accepted right after a compute transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_result |-> out_data.result_index == 4'(NELEM - 1))
    else $error("last flag on wrong element");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind matrix4x4_multiply mm4_checker u_mm4_checker (.*);

// ===== test/mm4_product_checker.sv =====
module mm4_product_checker import mm4_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  mm4_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  mm4_out_t out_data,
  output int       mismatches,
  output int       pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // four full-width products need two bits of headroom
  localparam int SUM_W = PROD_W + 2;

  logic signed [DATA_W-1:0] mat_a [NELEM];
  logic signed [DATA_W-1:0] mat_b [NELEM];
  mm4_out_t                 expected_products [$];
  int                       error_total = 0;

  always @(posedge clk) begin
    logic signed [SUM_W-1:0] dot_sum;
    logic signed [SUM_W-1:0] scaled;
    mm4_out_t                want;
    int                      col;
    int                      row;
    if (!rst_n) begin
      mismatches      <= 0;
      pending_results <= 0;
    end else begin
      if (in_valid && in_ready) begin
        case (in_data.req_type)
          REQ_LOAD_A: mat_a[in_data.element_index] = in_data.element_value;
          REQ_LOAD_B: mat_b[in_data.element_index] = in_data.element_value;
          REQ_COMPUTE: begin
            for (int i = 0; i < NELEM; i++) begin
              col     = i % DIM;
              row     = i / DIM;
              dot_sum = '0;
              for (int z = 0; z < DIM; z++) begin
                dot_sum += mat_a[col + DIM * z] * mat_b[z + DIM * row];
              end
              scaled = dot_sum >>> FRAC_BITS;
              // fits in 32 bits only if all bits above bit 31 copy the sign
              if (scaled[SUM_W-1:DATA_W-1] == '0 || scaled[SUM_W-1:DATA_W-1] == '1) begin
                want.product_value = scaled[DATA_W-1:0];
              end else if (scaled[SUM_W-1]) begin
                want.product_value = {1'b1, {(DATA_W-1){1'b0}}};
              end else begin
                want.product_value = {1'b0, {(DATA_W-1){1'b1}}};
              end
              want.result_index = 4'(i);
              want.last_result  = (i == NELEM - 1);
              expected_products.push_back(want);
            end
          end
          default: ;  // unused request code, no effect
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_products.size() == 0) begin
          error_total++;
          if (error_total <= 10) begin
            $display("%0t: unexpected product transaction: value %h idx %0d last %0b",
                     $realtime, out_data.product_value, out_data.result_index,
                     out_data.last_result);
          end
        end else begin
          want = expected_products.pop_front();
          if (out_data.product_value !== want.product_value ||
              out_data.result_index !== want.result_index ||
              out_data.last_result !== want.last_result) begin
            error_total++;
            if (error_total <= 10) begin
              $display("%0t: product mismatch: expected value %h idx %0d last %0b, got value %h idx %0d last %0b",
                       $realtime, want.product_value, want.result_index, want.last_result,
                       out_data.product_value, out_data.result_index,
                       out_data.last_result);
            end
          end
        end
      end

      mismatches      <= error_total;
      pending_results <= expected_products.size();
    end
  end

endmodule

// ===== test/matrix4x4_multiply_tb.sv =====
module matrix4x4_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mm4_pkg::*;

  localparam int         FRAC_BITS    = 16;
  localparam int         RANDOM_ITEMS = 160;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  typedef enum int {
    VAL_FULL,
    VAL_FINE,
    VAL_MID,
    VAL_CORNER
  } value_range_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  mm4_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mm4_out_t out_data;
  int       mismatches;
  int       pending_results;
  int       in_calm   = 0;
  int       out_calm  = 0;

  matrix4x4_multiply #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  mm4_product_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatches     (mismatches),
    .pending_results(pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly random gaps, now and then a stretch of back-to-back transactions
  task automatic draw_idle(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 40);
      gap  = 0;
    end else begin
      gap = $urandom_range(0, 13);
    end
  endtask

  function automatic logic [31:0] corner_value(int k);
    unique case (k % 8)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      4: return 32'hFFFF_FFFF;
      5: return 32'h0001_0000;
      6: return 32'hFFFF_0000;
      default: return 32'h0000_8000;
    endcase
  endfunction

  function automatic logic [31:0] element_draw(value_range_t range_pick);
    logic signed [17:0] fine_part;
    logic signed [24:0] mid_part;
    logic signed [31:0] widened;
    fine_part = 18'($urandom);
    mid_part  = 25'($urandom);
    unique case (range_pick)
      VAL_FINE:   widened = fine_part;  // sums stay in range, low bits exercise flooring
      VAL_MID:    widened = mid_part;   // sums land near the saturation limits
      VAL_CORNER: widened = corner_value($urandom_range(0, 7));
      default:    widened = $urandom;
    endcase
    return widened;
  endfunction

  task automatic send(input logic [1:0] kind, input logic [3:0] idx, input logic [31:0] value);
    int gap;
    draw_idle(in_calm, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= '{req_type: kind, element_index: idx, element_value: value};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  initial begin
    int gap;
    wait (rst_n);
    forever begin
      draw_idle(out_calm, gap);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int           items_sent;
    int           choice;
    int           burst_len;
    value_range_t range_pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // every element written before the first compute
    for (int i = 0; i < NELEM; i++) send(REQ_LOAD_A, 4'(i), corner_value(i));
    for (int i = 0; i < NELEM; i++) send(REQ_LOAD_B, 4'(i), corner_value(i + 3));
    send(REQ_COMPUTE, 4'hF, 32'hFFFF_FFFF);
    send(REQ_RESERVED, 4'h5, 32'h1234_5678);
    drain_results();
    send(REQ_COMPUTE, 4'h0, 32'h0000_0000);

    // column 0 saturates high, column 1 saturates low, column 2 floors a negative sum
    for (int z = 0; z < DIM; z++) begin
      send(REQ_LOAD_A, 4'(DIM * z), 32'h7FFF_FFFF);
      send(REQ_LOAD_A, 4'(1 + DIM * z), 32'h8000_0000);
      send(REQ_LOAD_A, 4'(2 + DIM * z), 32'hFFFF_FFFF);
      send(REQ_LOAD_B, 4'(z), 32'h7FFF_FFFF);
    end
    send(REQ_COMPUTE, 4'hA, 32'h5555_5555);
    drain_results();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      range_pick = value_range_t'($urandom_range(0, 3));
      choice     = $urandom_range(0, 5);
      if (choice == 0) begin
        // back-to-back compute, no new loads
      end else if (choice <= 2) begin
        for (int i = 0; i < NELEM; i++) send(REQ_LOAD_A, 4'(i), element_draw(range_pick));
        for (int i = 0; i < NELEM; i++) send(REQ_LOAD_B, 4'(i), element_draw(range_pick));
        items_sent += 2 * NELEM;
      end else begin
        burst_len = $urandom_range(1, 12);
        repeat (burst_len) begin
          if ($urandom_range(0, 11) == 0) send(REQ_RESERVED, 4'($urandom), $urandom);
          send($urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A, 4'($urandom),
               element_draw(range_pick));
        end
        items_sent += burst_len;
      end
      if ($urandom_range(0, 3) == 0) drain_results();
      send(REQ_COMPUTE, 4'($urandom), $urandom);
      items_sent++;
    end

    drain_results();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
